// ===== rtl/per_key_message_suppressor_unit_defines.svh =====
// assertion macros for the per-key message suppressor rtl
`ifndef PER_KEY_MESSAGE_SUPPRESSOR_UNIT_DEFINES_SVH
`define PER_KEY_MESSAGE_SUPPRESSOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked out of reset, on clk and rst_n of the enclosing module
`define PKMSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define PKMSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PKMSU_ASSERT(lbl, prop, msg)
`define PKMSU_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/pkmsu_pkg.sv =====
// types and constants of the per-key message suppressor
`timescale 1ns / 1ps

package pkmsu_pkg;

  localparam int TS_W     = 32;
  localparam int KEY_W    = 32;
  localparam int WINDOW_W = 16;

  typedef logic [TS_W-1:0]     ts_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [WINDOW_W-1:0] window_t;

  localparam window_t WINDOW_RESET = window_t'(10);

  // summary of one table lookup
  typedef struct packed {
    logic hit;          // key held by a valid entry
    logic hit_expired;  // that entry's window has run out
    logic spare_found;  // some entry is invalid or expired
  } lookup_flags_t;

endpackage

// ===== rtl/pkmsu_lookup.sv =====
// associative key compare, expiry check and free-entry pick over the table
`timescale 1ns / 1ps

module pkmsu_lookup #(
  parameter int ENTRIES = 16
) (
  input  logic                    ent_vld [ENTRIES],
  input  pkmsu_pkg::key_t         ent_key [ENTRIES],
  input  pkmsu_pkg::ts_t          ent_time [ENTRIES],
  input  pkmsu_pkg::key_t         req_key,
  input  pkmsu_pkg::ts_t          req_ts,
  input  pkmsu_pkg::window_t      window,
  output logic [ENTRIES-1:0]      hit_oh,
  output logic [ENTRIES-1:0]      spare_oh,
  output pkmsu_pkg::lookup_flags_t flags
);

  import pkmsu_pkg::*;

  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] expired_vec;
  logic [ENTRIES-1:0] spare_vec;
  ts_t                gap [ENTRIES];

  // per-entry compare and elapsed time, wrapping mod 2^32
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      gap[i]         = req_ts - ent_time[i];
      match_vec[i]   = ent_vld[i] && (ent_key[i] == req_key);
      expired_vec[i] = gap[i] >= ts_t'(window);
      spare_vec[i]   = !ent_vld[i] || expired_vec[i];
    end
  end

  // lowest numbered match and lowest numbered free entry
  assign hit_oh   = match_vec & (~match_vec + ENTRIES'(1));
  assign spare_oh = spare_vec & (~spare_vec + ENTRIES'(1));

  assign flags.hit         = |match_vec;
  assign flags.hit_expired = |(hit_oh & expired_vec);
  assign flags.spare_found = |spare_vec;

endmodule

// ===== rtl/per_key_message_suppressor_unit.sv =====
// per-key message suppressor: top level with request stage, table and result stage
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+--------------------------
//   request  | in_timestamp, in_message_key            | start high, busy low
//   result   | out_allow, out_table_overflow           | out_strobe, one cycle
//   config   | cfg_wr_data (window)                    | cfg_wr_en
//
// one request per cycle; results go via the request and result registers
// the table compare, expiry subtract and free-entry pick are combinational
// between the request register and the result register
// reset clears all entry valid bits and sets the window to 10; busy stays low
// the receiver cannot stall, so results are never held back
`timescale 1ns / 1ps
`include "per_key_message_suppressor_unit_defines.svh"

module per_key_message_suppressor_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  pkmsu_pkg::ts_t        in_timestamp,
  input  pkmsu_pkg::key_t       in_message_key,
  output logic                  out_strobe,
  output logic                  out_allow,
  output logic                  out_table_overflow,
  input  logic                  cfg_wr_en,
  input  pkmsu_pkg::window_t    cfg_wr_data
);

  import pkmsu_pkg::*;

  window_t            window_r;
  logic               req_vld_r;
  ts_t                req_ts_r;
  key_t               req_key_r;
  logic               ent_vld_r [TABLE_ENTRIES];
  key_t               ent_key_r [TABLE_ENTRIES];
  ts_t                ent_time_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hit_oh;
  logic [TABLE_ENTRIES-1:0] spare_oh;
  logic [TABLE_ENTRIES-1:0] wr_oh;
  lookup_flags_t      flags;
  logic               allow_nxt;
  logic               ovf_nxt;
  logic               out_strobe_r;
  logic               out_allow_r;
  logic               out_ovf_r;
  logic               all_vld;

  assign busy = 1'b0;

  // window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window_r <= cfg_wr_data;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else begin
      req_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_ts_r  <= in_timestamp;
      req_key_r <= in_message_key;
    end
  end

  // table lookup
  pkmsu_lookup #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_lookup (
    .ent_vld  (ent_vld_r),
    .ent_key  (ent_key_r),
    .ent_time (ent_time_r),
    .req_key  (req_key_r),
    .req_ts   (req_ts_r),
    .window   (window_r),
    .hit_oh   (hit_oh),
    .spare_oh (spare_oh),
    .flags    (flags)
  );

  // decision and entry to write
  always_comb begin
    if (flags.hit) begin
      allow_nxt = flags.hit_expired;
      ovf_nxt   = 1'b0;
      wr_oh     = hit_oh & {TABLE_ENTRIES{flags.hit_expired}};
    end else begin
      allow_nxt = 1'b1;
      ovf_nxt   = !flags.spare_found;
      wr_oh     = spare_oh;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ent_vld_r[i] <= 1'b0;
      end
    end else if (req_vld_r) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (wr_oh[i]) begin
          ent_vld_r[i] <= 1'b1;
        end
      end
    end
  end

  // entry keys and times
  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (wr_oh[i]) begin
          ent_key_r[i]  <= req_key_r;
          ent_time_r[i] <= req_ts_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= req_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req_vld_r) begin
      out_allow_r <= allow_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_allow          = out_allow_r;
  assign out_table_overflow = out_ovf_r;

  always_comb begin
    all_vld = 1'b1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      all_vld = all_vld && ent_vld_r[i];
    end
  end

  `PKMSU_ASSERT(a_req_gives_result, (start && !busy) |=> ##1 out_strobe, "request lost")
  `PKMSU_ASSERT(a_result_has_req, out_strobe |-> $past(req_vld_r), "result without request")
  `PKMSU_ASSERT(a_ovf_allows, (out_strobe && out_table_overflow) |-> out_allow,
                "overflow on a suppressed request")
  `PKMSU_ASSERT(a_ovf_full, (out_strobe && out_table_overflow) |-> all_vld,
                "overflow with an invalid entry")
  `PKMSU_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_strobe, "result strobe after reset")

endmodule

// ===== verif/tb_per_key_message_suppressor_unit.sv =====
// self-checking testbench for the per-key message suppressor unit
`timescale 1ns / 1ps

module tb_per_key_message_suppressor_unit;

  import pkmsu_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 6;

  // one predicted result
  typedef struct packed {
    logic allow;
    logic overflow;
  } verdict_t;

  // predicts the allow/suppress verdict of each request and checks results in order
  class suppress_checker;
    window_t  window;
    bit       slot_live[ENTRIES];
    key_t     slot_key[ENTRIES];
    ts_t      slot_stamp[ENTRIES];
    verdict_t pending_verdicts[$];
    int       errors;

    function new();
      window = WINDOW_RESET;
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      errors = 0;
    endfunction

    function void set_window(window_t w);
      window = w;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    // elapsed ticks wrap modulo 2^32
    function bit lapsed(int slot, ts_t now);
      ts_t gap;
      gap = now - slot_stamp[slot];
      return gap >= {16'b0, window};
    endfunction

    function void note_request(ts_t now, key_t key);
      verdict_t v;
      int hit;
      int spare;
      hit = -1;
      spare = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
      end
      v.overflow = 1'b0;
      if (hit >= 0) begin
        // known key: allowed only once its window has run out
        v.allow = lapsed(hit, now);
        if (v.allow) slot_stamp[hit] = now;
      end else begin
        // new key: take the lowest free or expired slot
        for (int i = 0; i < ENTRIES; i++) begin
          if (spare < 0 && (!slot_live[i] || lapsed(i, now))) spare = i;
        end
        v.allow = 1'b1;
        if (spare >= 0) begin
          slot_live[spare]  = 1'b1;
          slot_key[spare]   = key;
          slot_stamp[spare] = now;
        end else begin
          v.overflow = 1'b1;
        end
      end
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(logic allow, logic overflow);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        errors++;
        $error("result strobe with no request outstanding");
        return;
      end
      v = pending_verdicts.pop_front();
      if (allow !== v.allow) begin
        errors++;
        $error("allow: expected %0b, got %0b", v.allow, allow);
      end
      if (overflow !== v.overflow) begin
        errors++;
        $error("table_overflow: expected %0b, got %0b", v.overflow, overflow);
      end
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  ts_t     in_timestamp;
  key_t    in_message_key;
  logic    out_strobe;
  logic    out_allow;
  logic    out_table_overflow;
  logic    cfg_wr_en;
  window_t cfg_wr_data;

  suppress_checker sb;
  ts_t             ts_cursor;
  int              cycle_count;

  per_key_message_suppressor_unit #(
    .TABLE_ENTRIES(ENTRIES)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_timestamp      (in_timestamp),
    .in_message_key    (in_message_key),
    .out_strobe        (out_strobe),
    .out_allow         (out_allow),
    .out_table_overflow(out_table_overflow),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // observe config writes, accepted requests and result strobes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.set_window(cfg_wr_data);
      if (start && !busy) sb.note_request(in_timestamp, in_message_key);
      if (out_strobe) sb.check_result(out_allow, out_table_overflow);
    end
  end

  // present one request and hold it until accepted
  task automatic send_request(input ts_t ts, input key_t key);
    start          <= 1'b1;
    in_timestamp   <= ts;
    in_message_key <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold off until every outstanding request has its result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window(input window_t w);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // edges of the window, a full table, eviction of expired keys, time wrap
  task automatic directed_requests();
    send_request(32'd0, 32'h0000_0000);
    send_request(32'd0, 32'h0000_0000);
    send_request(32'd9, 32'h0000_0000);
    send_request(32'd10, 32'h0000_0000);
    send_request(32'd10, 32'hFFFF_FFFF);
    for (int k = 1; k <= ENTRIES - 2; k++) send_request(32'd11, key_t'(k));
    send_request(32'd12, 32'h5555_5555);
    send_request(32'd19, 32'hAAAA_AAAA);
    send_request(32'd20, 32'hAAAA_AAAA);
    send_request(32'd20, 32'h0000_0000);
    send_request(32'hFFFF_FFF8, 32'h1234_5678);
    send_request(32'h0000_0002, 32'h1234_5678);
    send_request(32'h0000_0003, 32'h1234_5678);
    // step backwards looks like a long gap
    send_request(32'h0000_0001, 32'h1234_5678);
    ts_cursor = 32'h0000_0001;
  endtask

  // random requests over a key pool sized around the table, in bursts
  task automatic random_phase(input window_t w, input int count);
    key_t pool[32];
    int   pool_used;
    int   span;
    int   pick;
    int   burst_left;
    ts_t  step;
    key_t key;
    write_window(w);
    foreach (pool[i]) pool[i] = $urandom;
    pool_used  = $urandom_range(8, 32);
    span       = int'(w);
    burst_left = $urandom_range(1, 30);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) step = $urandom_range(0, span / 4 + 1);
      else if (pick < 85) step = $urandom_range(span - 1, span + 1);
      else if (pick < 97) step = $urandom_range(0, 3 * span);
      else step = $urandom;
      ts_cursor = ts_cursor + step;
      if ($urandom_range(0, 49) == 0) ts_cursor = ts_cursor - $urandom_range(1, span);
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = pool[$urandom_range(0, pool_used - 1)];
      send_request(ts_cursor, key);
      burst_left--;
      if ($urandom_range(0, 199) == 0) drain();
      if (burst_left <= 0) begin
        pause($urandom_range(1, 8));
        // occasional long stretch with no gaps
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 30);
      end
    end
  endtask

  // reset, stimulus, final check
  initial begin
    sb             = new();
    cycle_count    = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_timestamp   = '0;
    in_message_key = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    ts_cursor      = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_requests();
    random_phase(window_t'(1), 200);
    random_phase(window_t'(16'hFFFF), 200);
    random_phase(window_t'($urandom_range(2, 64)), 200);
    random_phase(WINDOW_RESET, 200);
    random_phase(window_t'($urandom_range(1, 65535)), 200);

    drain();
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
